// ===== design/bfrx_pkg.sv =====
// Shared types and constants for the bus frame receiver with XOR checks.
`default_nettype none

package bfrx_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CountW = 9;
    localparam int unsigned StatW  = 3;
    localparam int unsigned CfgIdxW = 2;

    // Register indexes on the configuration channel
    localparam logic [CfgIdxW-1:0] REG_SOF_CODE      = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_SOF_CODE_ALT  = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_MAX_BODY_SIZE = 2'd2;
    localparam logic [CfgIdxW-1:0] REG_MIN_FRAME_LEN = 2'd3;

    // Reset values of the registers
    localparam logic [ByteW-1:0] RST_SOF_CODE      = 8'd85;
    localparam logic [ByteW-1:0] RST_SOF_CODE_ALT  = 8'd86;
    localparam logic [ByteW-1:0] RST_MAX_BODY_SIZE = 8'd128;
    localparam logic [ByteW-1:0] RST_MIN_FRAME_LEN = 8'd10;

    // Status codes reported on the last byte
    localparam logic [StatW-1:0] ST_GOOD     = 3'd0;
    localparam logic [StatW-1:0] ST_SHORT    = 3'd1;
    localparam logic [StatW-1:0] ST_TRAILER  = 3'd2;
    localparam logic [StatW-1:0] ST_HDR_XOR  = 3'd3;
    localparam logic [StatW-1:0] ST_BODY_XOR = 3'd4;
    localparam logic [StatW-1:0] ST_TOO_BIG  = 3'd5;

    // Frame layout
    localparam logic [CountW-1:0] HDR_FIRST    = 9'd2;
    localparam logic [CountW-1:0] HDR_LAST     = 9'd7;
    localparam logic [CountW-1:0] HDR_CHECK    = 9'd8;
    localparam logic [CountW-1:0] BODY_FIRST   = 9'd9;
    localparam logic [CountW-1:0] HDR_MIN_LEN  = 9'd9;
    localparam logic [CountW-1:0] BODY_MIN_LEN = 9'd12;
    localparam logic [CountW-1:0] LEN_OVERHEAD = 9'd3;
    localparam logic [CountW-1:0] BODY_TAIL    = 9'd2;

    typedef struct packed {
        logic [ByteW-1:0] sof_code;
        logic [ByteW-1:0] sof_code_alt;
        logic [ByteW-1:0] max_body_size;
        logic [ByteW-1:0] min_frame_length;
    } bfrx_cfg_t;

    typedef struct packed {
        logic [StatW-1:0] status;
        logic             last;
        logic [ByteW-1:0] byte_index;
        logic [ByteW-1:0] frame_byte;
    } bfrx_result_t;

endpackage

`default_nettype wire

// ===== design/bus_frame_receiver_xor_check_unit.sv =====
// Top level of the bus frame receiver with size limit and XOR checks.
//
// Usage:
//   s_* carries received serial bytes, one per transaction (tdata = rx_byte).
//   Zero break bytes are skipped; a frame opens on either start code. Each
//   frame byte leaves on m_*: tdata = {byte_index, frame_byte}, tlast marks
//   the final byte of a frame or an abort, tuser carries the status.
//   Skipped bytes produce no output transaction.
//   cfg_* writes one of four registers (start code, alternate start code,
//   max body size, min frame length); it is always ready. Write it only while
//   the block is idle.
// Latency and throughput:
//   One byte per cycle while m_tready is high. A result appears on m_* in the
//   cycle after its byte is accepted; all parsing and XOR updates happen in
//   the single logic level between the parser state and the output register.
// Reset:
//   rst_n clears the parser to waiting for sync, empties the output register
//   and loads the register reset values.
// Stall:
//   While a result waits on m_* with m_tready low, s_tready drops; input is
//   taken again in the cycle the result is consumed.
`default_nettype none

module bus_frame_receiver_xor_check_unit
    import bfrx_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // slave stream: received bytes
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,    // [7:0] rx_byte
    // master stream: frame bytes
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [15:0]             m_tdata,    // [7:0] frame_byte, [15:8] byte_index
    output logic                    m_tlast,    // last
    output logic [2:0]              m_tuser,    // [2:0] status
    // configuration write channel
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [7:0]         cfg_data
);

    bfrx_cfg_t    cfg;
    bfrx_result_t result;
    bfrx_result_t out_data;
    logic         emit;
    logic         load_ok;
    logic         in_en;

    assign cfg_ready = 1'b1;
    assign s_tready  = load_ok;
    assign in_en     = s_tvalid && load_ok;

    bfrx_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bfrx_parse u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .in_en   (in_en),
        .rx_byte (s_tdata),
        .emit    (emit),
        .result  (result)
    );

    bfrx_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_en     (in_en),
        .emit      (emit),
        .result    (result),
        .load_ok   (load_ok),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {out_data.byte_index, out_data.frame_byte};
    assign m_tlast = out_data.last;
    assign m_tuser = out_data.status;

endmodule

`default_nettype wire

// ===== design/bfrx_cfg.sv =====
// Configuration register file: start codes, size limit, minimum frame length.
`default_nettype none

module bfrx_cfg
    import bfrx_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire logic [CfgIdxW-1:0] wr_index,
    input  wire logic [ByteW-1:0]   wr_data,
    output bfrx_cfg_t               cfg
);

    bfrx_cfg_t cfg_reg;
    bfrx_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_SOF_CODE:      cfg_next.sof_code         = wr_data;
                REG_SOF_CODE_ALT:  cfg_next.sof_code_alt     = wr_data;
                REG_MAX_BODY_SIZE: cfg_next.max_body_size    = wr_data;
                REG_MIN_FRAME_LEN: cfg_next.min_frame_length = wr_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sof_code         <= RST_SOF_CODE;
            cfg_reg.sof_code_alt     <= RST_SOF_CODE_ALT;
            cfg_reg.max_body_size    <= RST_MAX_BODY_SIZE;
            cfg_reg.min_frame_length <= RST_MIN_FRAME_LEN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== design/bfrx_parse.sv =====
// Frame parser: sync/start detection, length tracking and running XOR checks.
`default_nettype none

module bfrx_parse
    import bfrx_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bfrx_cfg_t        cfg,
    input  wire logic             in_en,
    input  wire logic [ByteW-1:0] rx_byte,
    output logic                  emit,
    output bfrx_result_t          result
);

    localparam logic [1:0] PH_SYNC  = 2'd0;
    localparam logic [1:0] PH_START = 2'd1;
    localparam logic [1:0] PH_SIZE  = 2'd2;
    localparam logic [1:0] PH_DATA  = 2'd3;

    logic [1:0]        phase_reg,      phase_next;
    logic [CountW-1:0] exp_len_reg,    exp_len_next;
    logic [CountW-1:0] count_reg,      count_next;
    logic [ByteW-1:0]  size_copy_reg,  size_copy_next;
    logic [ByteW-1:0]  hdr_xor_reg,    hdr_xor_next;
    logic [ByteW-1:0]  body_xor_reg,   body_xor_next;
    logic              hdr_bad_reg,    hdr_bad_next;
    logic              body_bad_reg,   body_bad_next;

    logic              is_start;
    logic [CountW:0]   idx_inc;
    logic [CountW-1:0] min_len;

    assign is_start = (rx_byte == cfg.sof_code) || (rx_byte == cfg.sof_code_alt);
    assign idx_inc  = {1'b0, count_reg} + {{CountW{1'b0}}, 1'b1};
    assign min_len  = {1'b0, cfg.min_frame_length};

    always_comb
    begin
        phase_next     = phase_reg;
        exp_len_next   = exp_len_reg;
        count_next     = count_reg;
        size_copy_next = size_copy_reg;
        hdr_xor_next   = hdr_xor_reg;
        body_xor_next  = body_xor_reg;
        hdr_bad_next   = hdr_bad_reg;
        body_bad_next  = body_bad_reg;
        emit              = 1'b0;
        result.frame_byte = rx_byte;
        result.byte_index = '0;
        result.last       = 1'b0;
        result.status     = ST_GOOD;

        case (phase_reg)
            PH_SYNC, PH_START:
            begin
                if (phase_reg == PH_SYNC && rx_byte == '0)
                begin
                    phase_next = PH_START;
                end
                else if (is_start)
                begin
                    // open a new frame with every check cleared
                    phase_next     = PH_SIZE;
                    exp_len_next   = '0;
                    count_next     = 9'd1;
                    size_copy_next = '0;
                    hdr_xor_next   = '0;
                    body_xor_next  = '0;
                    hdr_bad_next   = 1'b0;
                    body_bad_next  = 1'b0;
                    emit           = 1'b1;
                end
                else if (phase_reg == PH_START && rx_byte != '0)
                begin
                    phase_next = PH_SYNC;
                end
            end
            PH_SIZE:
            begin
                emit              = 1'b1;
                result.byte_index = 8'd1;
                if (rx_byte > cfg.max_body_size)
                begin
                    phase_next    = PH_SYNC;
                    exp_len_next  = '0;
                    count_next    = '0;
                    result.last   = 1'b1;
                    result.status = ST_TOO_BIG;
                end
                else
                begin
                    phase_next     = PH_DATA;
                    size_copy_next = rx_byte;
                    exp_len_next   = {1'b0, rx_byte} + LEN_OVERHEAD;
                    count_next     = 9'd2;
                end
            end
            default:
            begin
                emit              = 1'b1;
                result.byte_index = count_reg[ByteW-1:0];
                if (count_reg >= HDR_FIRST && count_reg <= HDR_LAST)
                begin
                    hdr_xor_next = hdr_xor_reg ^ rx_byte;
                end
                else if (count_reg == HDR_CHECK)
                begin
                    hdr_bad_next = (rx_byte != hdr_xor_reg);
                end
                if (exp_len_reg >= BODY_MIN_LEN)
                begin
                    if (count_reg >= BODY_FIRST && count_reg < exp_len_reg - BODY_TAIL)
                    begin
                        body_xor_next = body_xor_reg ^ rx_byte;
                    end
                    else if (count_reg == exp_len_reg - BODY_TAIL)
                    begin
                        body_bad_next = (rx_byte != body_xor_reg);
                    end
                end
                count_next = idx_inc[CountW-1:0];
                if (idx_inc >= {1'b0, exp_len_reg})
                begin
                    // final byte: priority short, trailer, header, body
                    result.last = 1'b1;
                    if (exp_len_reg < min_len)
                    begin
                        result.status = ST_SHORT;
                    end
                    else if (rx_byte != size_copy_reg)
                    begin
                        result.status = ST_TRAILER;
                    end
                    else if (exp_len_reg >= HDR_MIN_LEN && hdr_bad_next)
                    begin
                        result.status = ST_HDR_XOR;
                    end
                    else if (exp_len_reg >= BODY_MIN_LEN && body_bad_next)
                    begin
                        result.status = ST_BODY_XOR;
                    end
                    else
                    begin
                        result.status = ST_GOOD;
                    end
                    phase_next     = PH_SYNC;
                    exp_len_next   = '0;
                    count_next     = '0;
                    size_copy_next = '0;
                    hdr_xor_next   = '0;
                    body_xor_next  = '0;
                    hdr_bad_next   = 1'b0;
                    body_bad_next  = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SYNC;
            exp_len_reg   <= '0;
            count_reg     <= '0;
            size_copy_reg <= '0;
            hdr_xor_reg   <= '0;
            body_xor_reg  <= '0;
            hdr_bad_reg   <= 1'b0;
            body_bad_reg  <= 1'b0;
        end
        else if (in_en)
        begin
            phase_reg     <= phase_next;
            exp_len_reg   <= exp_len_next;
            count_reg     <= count_next;
            size_copy_reg <= size_copy_next;
            hdr_xor_reg   <= hdr_xor_next;
            body_xor_reg  <= body_xor_next;
            hdr_bad_reg   <= hdr_bad_next;
            body_bad_reg  <= body_bad_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/bfrx_out.sv =====
// Output register stage: holds one result while the downstream side stalls.
`default_nettype none

module bfrx_out
    import bfrx_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_en,
    input  wire logic         emit,
    input  wire bfrx_result_t result,
    output logic              load_ok,
    output logic              out_valid,
    input  wire logic         out_ready,
    output bfrx_result_t      out_data
);

    logic         valid_reg;
    logic         valid_next;
    bfrx_result_t data_reg;

    // the stage can take a new result when empty or draining this cycle
    assign load_ok = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load_ok)
        begin
            valid_next = in_en && emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_ok && in_en && emit)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ===== design/bfrx_checker.sv =====
// Port-level checker for the frame receiver, bound to the top level.
`default_nettype none

module bfrx_checker
    import bfrx_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata,
    input wire logic        m_tlast,
    input wire logic [2:0]  m_tuser
);

    // a stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
    else $error("stalled output transaction changed");

    // input is refused only while a result is stuck
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
    else $error("s_tready low without output stall");

    // status is zero except on the last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> m_tuser == ST_GOOD)
    else $error("nonzero status on a non-final byte");

    // size abort only on the size byte, marked last
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == ST_TOO_BIG |-> m_tlast && m_tdata[15:8] == 8'd1)
    else $error("size abort at wrong position");

    // status codes above the size abort are never produced
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= ST_TOO_BIG)
    else $error("undefined status code");

endmodule

bind bus_frame_receiver_xor_check_unit bfrx_checker u_bfrx_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== dv/bfrx_frame_checker.sv =====
// Checker for the bus frame receiver: tracks register writes, predicts frame bytes, compares.
`default_nettype none

module bfrx_frame_checker
    import bfrx_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    input  wire logic               s_tready,
    input  wire logic [7:0]         s_tdata,
    input  wire logic               m_tvalid,
    input  wire logic               m_tready,
    input  wire logic [15:0]        m_tdata,
    input  wire logic               m_tlast,
    input  wire logic [2:0]         m_tuser,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [CfgIdxW-1:0] cfg_index,
    input  wire logic [7:0]         cfg_data,
    output int                      mismatches,
    output int                      pending,
    output int                      checked,
    output int                      frames_closed
);

    typedef enum logic [1:0] {SEEK_SYNC, SEEK_START, READ_SIZE, READ_DATA} rx_phase_t;

    bfrx_cfg_t    regs;
    rx_phase_t    phase;
    int unsigned  frame_len;
    int unsigned  pos;
    logic [7:0]   size_byte;
    logic [7:0]   hdr_sum;
    logic [7:0]   body_sum;
    bit           hdr_bad;
    bit           body_bad;

    bfrx_result_t expected_bytes[$];
    bfrx_result_t predicted;
    bfrx_result_t oldest;
    int           err_cnt;
    int           check_cnt;
    int           close_cnt;

    function automatic void clear_frame();
        phase     = SEEK_SYNC;
        frame_len = 0;
        pos       = 0;
        size_byte = '0;
        hdr_sum   = '0;
        body_sum  = '0;
        hdr_bad   = 1'b0;
        body_bad  = 1'b0;
    endfunction

    // Advance the parser by one received byte; returns 1 when a frame byte is due.
    function automatic bit predict_frame_byte(input logic [7:0] b, output bfrx_result_t res);
        bit          is_start;
        int unsigned idx;
        int unsigned len;
        is_start = (b == regs.sof_code) || (b == regs.sof_code_alt);
        res = '0;
        res.frame_byte = b;
        res.status = ST_GOOD;
        case (phase)
            SEEK_SYNC, SEEK_START:
            begin
                if (phase == SEEK_SYNC && b == 8'h00)
                begin
                    phase = SEEK_START;
                end
                else if (is_start)
                begin
                    clear_frame();
                    phase = READ_SIZE;
                    pos = 1;
                    return 1'b1;
                end
                else if (phase == SEEK_START && b != 8'h00)
                begin
                    // stray byte after breaks: back to hunting
                    phase = SEEK_SYNC;
                end
                return 1'b0;
            end
            READ_SIZE:
            begin
                res.byte_index = 8'd1;
                if (b > regs.max_body_size)
                begin
                    clear_frame();
                    res.last = 1'b1;
                    res.status = ST_TOO_BIG;
                    return 1'b1;
                end
                size_byte = b;
                frame_len = b + LEN_OVERHEAD;
                pos = 2;
                phase = READ_DATA;
                return 1'b1;
            end
            default:
            begin
                idx = pos;
                len = frame_len;
                if (idx >= HDR_FIRST && idx <= HDR_LAST)
                    hdr_sum ^= b;
                else if (idx == HDR_CHECK)
                    hdr_bad = (b != hdr_sum);
                if (len >= BODY_MIN_LEN)
                begin
                    if (idx >= BODY_FIRST && idx < len - BODY_TAIL)
                        body_sum ^= b;
                    else if (idx == len - BODY_TAIL)
                        body_bad = (b != body_sum);
                end
                pos = (idx + 1) & 'h1FF;
                res.byte_index = idx[7:0];
                if (idx + 1 < len)
                    return 1'b1;
                res.last = 1'b1;
                if (len < regs.min_frame_length)
                    res.status = ST_SHORT;
                else if (b != size_byte)
                    res.status = ST_TRAILER;
                else if (len >= HDR_MIN_LEN && hdr_bad)
                    res.status = ST_HDR_XOR;
                else if (len >= BODY_MIN_LEN && body_bad)
                    res.status = ST_BODY_XOR;
                clear_frame();
                return 1'b1;
            end
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        err_cnt++;
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.sof_code         = RST_SOF_CODE;
            regs.sof_code_alt     = RST_SOF_CODE_ALT;
            regs.max_body_size    = RST_MAX_BODY_SIZE;
            regs.min_frame_length = RST_MIN_FRAME_LEN;
            clear_frame();
            expected_bytes.delete();
            err_cnt   = 0;
            check_cnt = 0;
            close_cnt = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (predict_frame_byte(s_tdata, predicted))
                    expected_bytes.insert(expected_bytes.size(), predicted);
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    report_mismatch("unexpected frame byte", m_tdata, 0);
                end
                else
                begin
                    oldest = expected_bytes.pop_front();
                    if (m_tdata[7:0] != oldest.frame_byte)
                        report_mismatch("frame_byte", m_tdata[7:0], oldest.frame_byte);
                    if (m_tdata[15:8] != oldest.byte_index)
                        report_mismatch("byte_index", m_tdata[15:8], oldest.byte_index);
                    if (m_tlast != oldest.last)
                        report_mismatch("last", m_tlast, oldest.last);
                    if (m_tuser != oldest.status)
                        report_mismatch("status", m_tuser, oldest.status);
                    check_cnt++;
                    if (oldest.last)
                        close_cnt++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_SOF_CODE:      regs.sof_code         = cfg_data;
                    REG_SOF_CODE_ALT:  regs.sof_code_alt     = cfg_data;
                    REG_MAX_BODY_SIZE: regs.max_body_size    = cfg_data;
                    REG_MIN_FRAME_LEN: regs.min_frame_length = cfg_data;
                    default: ;
                endcase
            end
        end
        mismatches    <= err_cnt;
        pending       <= expected_bytes.size();
        checked       <= check_cnt;
        frames_closed <= close_cnt;
    end

endmodule

`default_nettype wire

// ===== dv/bus_frame_receiver_xor_check_unit_tb.sv =====
// Testbench top for the bus frame receiver: stimulus, handshake pacing and the verdict.
`default_nettype none

module bus_frame_receiver_xor_check_unit_tb;
    import bfrx_pkg::*;

    // Generous bound: ~1400 bytes, each worst case a sender gap plus an RX_LONG
    // receiver stall, stay well under this limit.
    localparam int CYCLE_LIMIT   = 400000;
    // Output appears in the cycle after acceptance; the spare cycles here cover
    // bytes that produce no transaction.
    localparam int SETTLE_CYCLES = 4;
    // Covers the longest frame: largest size byte plus start, size and trailer
    localparam int FRAME_MAX     = 259;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC, RX_LONG} rx_pattern_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;    // [7:0] rx_byte
    logic               m_tvalid;
    logic               m_tready;
    logic [15:0]        m_tdata;    // [7:0] frame_byte, [15:8] byte_index
    logic               m_tlast;    // last
    logic [2:0]         m_tuser;    // [2:0] status
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CfgIdxW-1:0] cfg_index;
    logic [7:0]         cfg_data;

    int mismatches;
    int pending;
    int checked;
    int frames_closed;

    // Stimulus-side copy of the registers, used to pick start codes and sizes
    bfrx_cfg_t   cfg_now;
    int          gap_max;
    rx_pattern_t rx_mode;
    int          burst_left;
    int          bytes_sent;
    int          settings_used;
    int          stall_tick;
    int          cycle_count;

    bus_frame_receiver_xor_check_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predicts every frame byte and compares each output transaction
    bfrx_frame_checker u_frame_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending),
        .checked       (checked),
        .frames_closed (frames_closed)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver backpressure: one assignment per falling edge, pattern chosen per phase
    always @(negedge clk)
    begin
        stall_tick++;
        case (rx_mode)
            RX_ALWAYS:   m_tready <= 1'b1;
            RX_RANDOM:   m_tready <= ($urandom_range(0, 99) >= 30);
            RX_PERIODIC: m_tready <= ((stall_tick % 7) >= 3);
            default:     m_tready <= ((stall_tick % 32) >= 20);   // long stalls
        endcase
    end

    // One byte transaction on the slave stream. Bursts of random length with
    // random gaps; gap_max of zero gives back-to-back bytes.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
    endtask

    // Sender pauses until every expected frame byte has come out
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SOF_CODE:      cfg_now.sof_code         = val;
            REG_SOF_CODE_ALT:  cfg_now.sof_code_alt     = val;
            REG_MAX_BODY_SIZE: cfg_now.max_body_size    = val;
            default:           cfg_now.min_frame_length = val;
        endcase
    endtask

    // New register set, written only once the block has drained
    task automatic load_setting(input logic [7:0] sc, input logic [7:0] alt,
                                input logic [7:0] max_size, input logic [7:0] min_len);
        settle();
        write_reg(REG_SOF_CODE, sc);
        write_reg(REG_SOF_CODE_ALT, alt);
        write_reg(REG_MAX_BODY_SIZE, max_size);
        write_reg(REG_MIN_FRAME_LEN, min_len);
        settings_used++;
    endtask

    // Builds a frame of size+3 bytes with correct header and body XOR bytes and
    // a matching trailer, optionally spoils checks, and sends the first keep bytes.
    // Returns the number of bytes sent.
    task automatic send_frame(input logic [7:0] start, input int size, input int keep,
                              input bit bad_hdr, input bit bad_body, input bit bad_trail,
                              output int sent);
        logic [7:0] fb[FRAME_MAX];
        int         len;
        logic [7:0] sum;
        len = size + int'(LEN_OVERHEAD);
        fb[0] = start;
        fb[1] = 8'(size);
        for (int i = 2; i < len; i++)
            fb[i] = 8'($urandom_range(0, 255));
        if (len >= int'(HDR_MIN_LEN))
        begin
            sum = '0;
            for (int i = int'(HDR_FIRST); i <= int'(HDR_LAST); i++)
                sum ^= fb[i];
            fb[HDR_CHECK] = sum ^ (bad_hdr ? 8'($urandom_range(1, 255)) : 8'h00);
        end
        if (len >= int'(BODY_MIN_LEN))
        begin
            sum = '0;
            for (int i = int'(BODY_FIRST); i < len - int'(BODY_TAIL); i++)
                sum ^= fb[i];
            fb[len - int'(BODY_TAIL)] = sum ^ (bad_body ? 8'($urandom_range(1, 255)) : 8'h00);
        end
        // In a nine-byte frame the trailer overwrites the header check byte
        fb[len - 1] = 8'(size) ^ (bad_trail ? 8'($urandom_range(1, 255)) : 8'h00);
        sent = 0;
        for (int i = 0; i < len && i < keep; i++)
        begin
            send_byte(fb[i]);
            sent++;
        end
    endtask

    function automatic logic [7:0] pick_start();
        return $urandom_range(0, 1) ? cfg_now.sof_code : cfg_now.sof_code_alt;
    endfunction

    // Random traffic: mostly frames with random content, well-formed or with
    // spoiled checks or truncated, plus oversize aborts and line noise.
    task automatic run_traffic(input int n_items, input int gaps, input rx_pattern_t pat);
        int items;
        int r;
        int hi;
        int size;
        int len;
        int keep;
        int spoil;
        int sent;
        int k;
        gap_max = gaps;
        rx_mode = pat;
        items = 0;
        while (items < n_items)
        begin
            hi = cfg_now.max_body_size;
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3)) send_byte(8'h00);
            r = $urandom_range(0, 99);
            if (r < 88)
            begin
                k = $urandom_range(0, 99);
                if (k < 85)
                    size = $urandom_range(0, (hi < 16) ? hi : 16);
                else if (k < 97)
                    size = $urandom_range(0, (hi < 60) ? hi : 60);
                else
                    size = $urandom_range(0, hi);
                len = size + int'(LEN_OVERHEAD);
                keep = (r < 78) ? len : $urandom_range(1, len - 1);
                spoil = $urandom_range(0, 9);
                send_frame(pick_start(), size, keep,
                           spoil == 5 || spoil >= 8,
                           spoil == 6 || spoil >= 8,
                           spoil == 7 || spoil == 9, sent);
                items += sent;
            end
            else if (r < 94 && hi < 255)
            begin
                // size byte above the limit aborts the frame
                send_byte(pick_start());
                send_byte(8'($urandom_range(hi + 1, 255)));
                items += 2;
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    k = $urandom_range(0, 9);
                    if (k < 4)
                        send_byte(8'h00);
                    else if (k < 6)
                        send_byte(pick_start());
                    else
                        send_byte(8'($urandom_range(0, 255)));
                end
            end
            if ($urandom_range(0, 39) == 0)
                settle();
        end
    endtask

    initial
    begin
        int sent;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_SOF_CODE;
        cfg_data      = '0;
        rx_mode       = RX_ALWAYS;
        gap_max       = 0;
        burst_left    = 0;
        bytes_sent    = 0;
        settings_used = 1;
        stall_tick    = 0;
        cycle_count   = 0;
        cfg_now.sof_code         = RST_SOF_CODE;
        cfg_now.sof_code_alt     = RST_SOF_CODE_ALT;
        cfg_now.max_body_size    = RST_MAX_BODY_SIZE;
        cfg_now.min_frame_length = RST_MIN_FRAME_LEN;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: stray bytes while hunting, stray byte after a break, a
        // minimal frame reported short, an abort one above the size limit, and
        // a twelve-byte frame with both XOR checks passing.
        send_byte(8'h11);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h7E);
        send_byte(8'h00);
        send_frame(RST_SOF_CODE, 0, 3, 1'b0, 1'b0, 1'b0, sent);
        send_byte(RST_SOF_CODE_ALT);
        send_byte(RST_MAX_BODY_SIZE + 8'd1);
        send_frame(RST_SOF_CODE, 9, 12, 1'b0, 1'b0, 1'b0, sent);

        // Reset register values
        run_traffic(300, 3, RX_RANDOM);
        // Extremes: zero start code, all-ones alternate, widest size, nothing short
        load_setting(8'h00, 8'hFF, 8'hFF, 8'h00);
        run_traffic(250, 0, RX_ALWAYS);
        // Opposite extremes: only empty bodies, every frame short
        load_setting(8'hFF, 8'hA5, 8'h00, 8'hFF);
        run_traffic(150, 6, RX_PERIODIC);
        // Both start codes equal; nine-byte frames count as full length
        load_setting(8'h3C, 8'h3C, 8'd12, 8'd9);
        run_traffic(200, 2, RX_LONG);
        load_setting(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(8, 40)), 8'($urandom_range(0, 20)));
        run_traffic(250, 4, RX_RANDOM);
        load_setting(RST_SOF_CODE, RST_SOF_CODE_ALT, RST_MAX_BODY_SIZE,
                     RST_MIN_FRAME_LEN);
        run_traffic(150, 1, RX_PERIODIC);

        // Drain, then allow the output register time to show anything stray
        settle();
        repeat (4 * SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d received bytes under %0d register settings.",
                 bytes_sent, settings_used);
        $display("%0d frame byte transactions compared, %0d of them frame ends or aborts.",
                 checked, frames_closed);
        if (mismatches == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
